// ===== hdl/vefd_pkg.sv =====
// Shared types, constants and codes of the varint extent frame decoder.
`default_nettype none

package vefd_pkg;

   localparam int STREAM_COUNT  = 256;
   localparam int SLOT_W        = $clog2(STREAM_COUNT);
   localparam int TRAILER_BYTES = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] TRAILER_LEN = 16'(TRAILER_BYTES);
   localparam logic [15:0] HDR_LEN     = 16'd10;
   localparam logic [31:0] HDR_MAGIC   = 32'h5056_5254;
   localparam logic [40:0] SAT41       = 41'h1FF_FFFF_FFFF;
   localparam logic [40:0] REGION_RESET = 41'h000_8000_0000;

   // result kinds
   localparam logic [1:0] KIND_IN  = 2'd0;
   localparam logic [1:0] KIND_OUT = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   // frame status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_NOHDR  = 3'd2;
   localparam logic [2:0] ST_BADSID = 3'd3;
   localparam logic [2:0] ST_PAIR   = 3'd4;

   // register indexes
   localparam logic CSR_HEADER_SKIP = 1'b0;
   localparam logic CSR_REGION_SIZE = 1'b1;

   // operations from parser to executor
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_SID  = 2'd1;
   localparam logic [1:0] OP_EXT  = 2'd2;
   localparam logic [1:0] OP_FIN  = 2'd3;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
      logic        first_of_frame;
      logic        last_of_frame;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [40:0] extent_offset;
      logic [40:0] extent_length;
      logic [7:0]  stream_id;
      logic [2:0]  frame_status;
      logic [40:0] frame_bytes;
   } rsp_type;

   // one classified byte, front to back
   typedef struct packed {
      logic       start;
      logic       drop;
      logic [2:0] drop_status;
      logic       proc;
      logic [7:0] data;
      logic       beyond;
      logic [7:0] shift;
      logic       fin;
      logic       early;
      logic       incomplete;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] lu;
      logic [63:0] delta;
      logic [7:0]  shift;
      logic [7:0]  stream;
      logic [2:0]  status;
      logic        store;
   } op_type;

endpackage

`default_nettype wire

// ===== hdl/vefd_front.sv =====
// Front end: frame tracking, link header skip and frame header detection.
`default_nettype none

module vefd_front import vefd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic [7:0] header_skip,
   output logic       push,
   output cmd_type    push_cmd,
   input  logic       q_full
);

   localparam logic [2:0] FP_IDLE = 3'd0;
   localparam logic [2:0] FP_SKIP = 3'd1;
   localparam logic [2:0] FP_HEAD = 3'd2;
   localparam logic [2:0] FP_PAY  = 3'd3;
   localparam logic [2:0] FP_DROP = 3'd4;

   logic [2:0]  ph_ff, ph_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] flen_ff, flen_in;
   logic [7:0]  skip_ff, skip_in;
   logic        reqd_ff, reqd_in;
   logic [31:0] win_ff, win_in;
   logic [7:0]  shift_ff, shift_in;
   logic        found_ff, found_in;
   logic [15:0] bend_ff, bend_in;
   logic        rep_act_ff, rep_act_in;
   logic [1:0]  rep_cnt_ff, rep_cnt_in;
   logic        rep_last_ff, rep_last_in;

   logic accept;

   assign req_ready = !rep_act_ff && !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [15:0] off;
      logic [15:0] room;
      logic [16:0] after;
      logic [17:0] hend;
      logic [15:0] lim;
      logic [7:0]  b;
      ph_in       = ph_ff;
      pos_in      = pos_ff;
      flen_in     = flen_ff;
      skip_in     = skip_ff;
      reqd_in     = reqd_ff;
      win_in      = win_ff;
      shift_in    = shift_ff;
      found_in    = found_ff;
      bend_in     = bend_ff;
      rep_act_in  = rep_act_ff;
      rep_cnt_in  = rep_cnt_ff;
      rep_last_in = rep_last_ff;
      push_cmd    = '0;
      push        = 1'b0;
      off         = '0;
      room        = '0;
      after       = '0;
      hend        = '0;
      lim         = '0;
      b           = req_data.data_byte;
      if (rep_act_ff) begin
         // no magic: feed the four held bytes to the parser
         if (!q_full) begin
            push              = 1'b1;
            push_cmd.proc     = 1'b1;
            push_cmd.data     = win_ff[{rep_cnt_ff, 3'b000} +: 8];
            push_cmd.beyond   = ({8'b0, skip_ff} + {14'b0, rep_cnt_ff}) >= bend_ff;
            push_cmd.shift    = found_ff ? shift_ff : 8'd0;
            push_cmd.fin      = rep_last_ff && (rep_cnt_ff == 2'd3);
            rep_cnt_in        = rep_cnt_ff + 2'd1;
            if (rep_cnt_ff == 2'd3) rep_act_in = 1'b0;
         end
      end else if (accept) begin
         if (req_data.first_of_frame) begin
            push_cmd.start = 1'b1;
            pos_in   = '0;
            win_in   = '0;
            found_in = 1'b0;
            shift_in = '0;
            bend_in  = '0;
            flen_in  = req_data.frame_length;
            reqd_in  = header_skip != 8'd0;
            skip_in  = (header_skip != 8'd0 && {8'b0, header_skip} < req_data.frame_length)
                       ? header_skip : 8'd0;
            if (req_data.frame_length < TRAILER_LEN) begin
               ph_in = FP_DROP;
               push_cmd.drop        = 1'b1;
               push_cmd.drop_status = ST_SHORT;
            end else begin
               ph_in = FP_SKIP;
            end
         end
         if (req_data.first_of_frame || ph_ff != FP_IDLE) begin
            if (req_data.last_of_frame && ({1'b0, pos_in} + 17'd1) < {1'b0, flen_in}) begin
               push_cmd.fin   = 1'b1;
               push_cmd.early = 1'b1;
               ph_in = FP_IDLE;
            end else begin
               if (pos_in < flen_in) begin
                  if (ph_in == FP_SKIP && pos_in >= {8'b0, skip_in}) begin
                     room = flen_in - {8'b0, skip_in};
                     if (room >= HDR_LEN) begin
                        ph_in = FP_HEAD;
                     end else if (reqd_in) begin
                        ph_in = FP_DROP;
                        push_cmd.drop        = 1'b1;
                        push_cmd.drop_status = ST_NOHDR;
                     end else begin
                        bend_in = (flen_in > TRAILER_LEN &&
                                   {8'b0, skip_in} < flen_in - TRAILER_LEN)
                                  ? flen_in - TRAILER_LEN : {8'b0, skip_in};
                        ph_in = FP_PAY;
                     end
                  end
                  if (ph_in == FP_PAY) begin
                     push_cmd.proc   = 1'b1;
                     push_cmd.data   = b;
                     push_cmd.beyond = pos_in >= bend_in;
                  end else if (ph_in == FP_HEAD) begin
                     off = pos_in - {8'b0, skip_in};
                     if (off < 16'd4) begin
                        win_in = {b, win_in[31:8]};
                        if (off == 16'd3) begin
                           if (win_in != HDR_MAGIC) begin
                              if (reqd_in) begin
                                 ph_in = FP_DROP;
                                 push_cmd.drop        = 1'b1;
                                 push_cmd.drop_status = ST_NOHDR;
                              end else begin
                                 bend_in     = flen_in - TRAILER_LEN;
                                 ph_in       = FP_PAY;
                                 rep_act_in  = 1'b1;
                                 rep_cnt_in  = 2'd0;
                                 rep_last_in = req_data.last_of_frame;
                              end
                           end else begin
                              win_in = '0;
                           end
                        end
                     end else if (off == 16'd5) begin
                        shift_in = b;
                     end else if (off == 16'd6) begin
                        win_in = {24'b0, b};
                     end else if (off == 16'd7) begin
                        win_in[15:8] = b;
                     end else if (off == 16'd9) begin
                        after = {9'b0, skip_in} + {1'b0, HDR_LEN};
                        lim   = flen_in - TRAILER_LEN;
                        hend  = {1'b0, after} + {2'b0, win_in[15:0]};
                        if (hend > {2'b0, lim}) hend = {2'b0, lim};
                        found_in = 1'b1;
                        if (hend < {1'b0, after}) begin
                           ph_in = FP_DROP;
                           push_cmd.drop        = 1'b1;
                           push_cmd.drop_status = ST_BADSID;
                        end else begin
                           bend_in = hend[15:0];
                           ph_in   = FP_PAY;
                        end
                     end
                  end
               end
               if (req_data.last_of_frame) begin
                  if (!rep_act_in) begin
                     push_cmd.fin        = 1'b1;
                     push_cmd.incomplete = (ph_in == FP_SKIP) || (ph_in == FP_HEAD);
                  end
                  ph_in = FP_IDLE;
               end
               if (pos_in != 16'hFFFF) pos_in = pos_in + 16'd1;
            end
         end
         push_cmd.shift = found_in ? shift_in : 8'd0;
         push = push_cmd.start || push_cmd.drop || push_cmd.proc || push_cmd.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff      <= FP_IDLE;
         rep_act_ff <= 1'b0;
         rep_cnt_ff <= '0;
      end else begin
         ph_ff      <= ph_in;
         rep_act_ff <= rep_act_in;
         rep_cnt_ff <= rep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      flen_ff     <= flen_in;
      skip_ff     <= skip_in;
      reqd_ff     <= reqd_in;
      win_ff      <= win_in;
      shift_ff    <= shift_in;
      found_ff    <= found_in;
      bend_ff     <= bend_in;
      rep_last_ff <= rep_last_in;
   end

endmodule

`default_nettype wire

// ===== hdl/vefd_queue.sv =====
// Short request queue between front and back end.
`default_nettype none

module vefd_queue import vefd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type                slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = cnt_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slots[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_PTR_W + 1)'(do_push) - (QUEUE_PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots[wr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// ===== hdl/vefd_parse.sv =====
// Back end stage one: LEB128 stream id and pair parsing, frame status.
`default_nettype none

module vefd_parse import vefd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    q_empty,
   input  cmd_type q_cmd,
   output logic    pop,
   output logic    op_vld,
   output op_type  op
);

   localparam logic [2:0] BP_IDLE = 3'd0;
   localparam logic [2:0] BP_SID  = 3'd1;
   localparam logic [2:0] BP_PU   = 3'd2;
   localparam logic [2:0] BP_PL   = 3'd3;
   localparam logic [2:0] BP_DONE = 3'd4;
   localparam logic [2:0] BP_DROP = 3'd5;

   logic [2:0]  ph_ff, ph_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  stream_ff, stream_in;
   logic [63:0] delta_ff, delta_in;
   logic        op_vld_ff;
   op_type      op_ff, op_new;

   assign pop    = adv && !q_empty;
   assign op_vld = op_vld_ff;
   assign op     = op_ff;

   always_comb begin
      logic [63:0] acc2;
      logic [6:0]  cnt7;
      logic        done, over;
      ph_in     = ph_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      stream_in = stream_ff;
      delta_in  = delta_ff;
      op_new    = '0;
      op_new.op = OP_NONE;
      acc2      = '0;
      cnt7      = '0;
      done      = 1'b0;
      over      = 1'b0;
      if (q_cmd.start) begin
         op_new.start = 1'b1;
         ph_in     = BP_SID;
         acc_in    = '0;
         cnt_in    = '0;
         status_in = ST_OK;
         stream_in = '0;
      end
      if (q_cmd.drop) begin
         ph_in     = BP_DROP;
         status_in = q_cmd.drop_status;
      end
      if (q_cmd.proc) begin
         acc2 = acc_in | (cnt_in[6] ? 64'b0 : ({57'b0, q_cmd.data[6:0]} << cnt_in[5:0]));
         cnt7 = cnt_in + 7'd7;
         done = !q_cmd.data[7];
         over = cnt7 > 7'd63;
         case (ph_in)
            BP_SID: begin
               if (q_cmd.beyond || (!done && over)) begin
                  ph_in     = BP_DROP;
                  status_in = ST_BADSID;
               end else if (done) begin
                  stream_in = acc2[7:0];
                  op_new.op = OP_SID;
                  acc_in    = '0;
                  cnt_in    = '0;
                  ph_in     = BP_PU;
               end else begin
                  acc_in = acc2;
                  cnt_in = cnt7;
               end
            end
            BP_PU: begin
               if (q_cmd.beyond) begin
                  if (cnt_in != 7'd0) status_in = ST_PAIR;
                  ph_in = BP_DONE;
               end else if (done) begin
                  // zigzag decode
                  delta_in = (acc2 >> 1) ^ {64{acc2[0]}};
                  acc_in   = '0;
                  cnt_in   = '0;
                  ph_in    = BP_PL;
               end else if (over) begin
                  status_in = ST_PAIR;
                  ph_in     = BP_DONE;
               end else begin
                  acc_in = acc2;
                  cnt_in = cnt7;
               end
            end
            BP_PL: begin
               if (q_cmd.beyond || (!done && over)) begin
                  status_in = ST_PAIR;
                  ph_in     = BP_DONE;
               end else if (done) begin
                  op_new.op    = OP_EXT;
                  op_new.lu    = acc2;
                  op_new.delta = delta_in;
                  acc_in       = '0;
                  cnt_in       = '0;
                  ph_in        = BP_PU;
               end else begin
                  acc_in = acc2;
                  cnt_in = cnt7;
               end
            end
            default: begin
            end
         endcase
      end
      if (q_cmd.fin) begin
         op_new.op = OP_FIN;
         if (q_cmd.early) begin
            op_new.status = ST_SHORT;
            op_new.store  = 1'b0;
         end else begin
            if (q_cmd.incomplete || ph_in == BP_SID) begin
               status_in = ST_BADSID;
               ph_in     = BP_DROP;
            end else if (ph_in == BP_PL || (ph_in == BP_PU && cnt_in != 7'd0)) begin
               status_in = ST_PAIR;
            end
            op_new.status = status_in;
            op_new.store  = ph_in != BP_DROP;
         end
         ph_in = BP_IDLE;
      end
      op_new.shift  = q_cmd.shift;
      op_new.stream = stream_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= BP_IDLE;
         op_vld_ff <= 1'b0;
      end else if (adv) begin
         op_vld_ff <= !q_empty && (op_new.op != OP_NONE || op_new.start);
         if (!q_empty) ph_ff <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         stream_ff <= stream_in;
         delta_ff  <= delta_in;
         op_ff     <= op_new;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vefd_exec.sv =====
// Back end stages two and three: stream offset table, extent arithmetic, result register.
`default_nettype none

module vefd_exec import vefd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [40:0] region_size,
   input  logic        op_vld,
   input  op_type      op,
   output logic        adv,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic [63:0]       table_mem [STREAM_COUNT];
   logic              table_vld_ff [STREAM_COUNT];
   logic [SLOT_W-1:0] slot;
   logic [SLOT_W-1:0] slot_ff;
   logic [63:0]       run_ff;
   logic              rd_pend_ff;
   logic [63:0]       rd_data_ff;
   logic              rd_vld_ff;

   logic        s3_vld_ff;
   logic        s3_start_ff;
   logic [1:0]  s3_op_ff;
   logic [40:0] s3_run_lo_ff;
   logic        s3_hi0_ff;
   logic [40:0] s3_len_ff;
   logic        s3_sat_ff;
   logic [7:0]  s3_stream_ff;
   logic [2:0]  s3_status_ff;

   logic [40:0] eff_ff, eff_in;
   logic        rsp_vld_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        produce;

   logic [63:0] run_eff, new_run;
   logic        sat;
   logic [40:0] len;
   logic        store_now;

   assign adv       = !rsp_vld_ff || rsp_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign slot      = SLOT_W'(op.stream % STREAM_COUNT);
   assign store_now = adv && op_vld && op.op == OP_FIN && op.store;

   // stage two: offset update and length scaling
   always_comb begin
      run_eff = rd_pend_ff ? (rd_vld_ff ? rd_data_ff : {24'b0, region_size[40:1]}) : run_ff;
      new_run = run_eff + op.delta;
      sat = (op.lu != 64'd0) &&
            ((op.shift >= 8'd41) || ((op.lu >> (6'd41 - op.shift[5:0])) != 64'd0));
      len = sat ? SAT41 : (op.lu[40:0] << op.shift[5:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         s3_vld_ff  <= 1'b0;
      end else if (adv) begin
         rd_pend_ff <= op_vld && op.op == OP_SID;
         s3_vld_ff  <= op_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         run_ff <= (op_vld && op.op == OP_EXT) ? new_run : run_eff;
         if (op_vld && op.op == OP_SID) begin
            slot_ff    <= slot;
            rd_data_ff <= table_mem[slot];
            rd_vld_ff  <= table_vld_ff[slot];
         end
         if (store_now) table_mem[slot_ff] <= run_eff;
         s3_start_ff  <= op.start;
         s3_op_ff     <= op.op;
         s3_run_lo_ff <= new_run[40:0];
         s3_hi0_ff    <= new_run[63:41] == '0;
         s3_len_ff    <= len;
         s3_sat_ff    <= sat;
         s3_stream_ff <= op.stream;
         s3_status_ff <= op.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STREAM_COUNT; i++) table_vld_ff[i] <= 1'b0;
      end else if (store_now) begin
         table_vld_ff[slot_ff] <= 1'b1;
      end
   end

   // stage three: range check and byte count
   always_comb begin
      logic [40:0] eff_base;
      logic [41:0] sum;
      logic [41:0] effsum;
      logic        ok;
      eff_base = s3_start_ff ? 41'd0 : eff_ff;
      sum      = {1'b0, s3_run_lo_ff} + {1'b0, s3_len_ff};
      effsum   = {1'b0, eff_base} + {1'b0, s3_len_ff};
      ok       = !s3_sat_ff && s3_hi0_ff && (sum <= {1'b0, region_size});
      rsp_in   = '0;
      eff_in   = eff_base;
      produce  = 1'b0;
      case (s3_op_ff)
         OP_EXT: begin
            produce              = 1'b1;
            rsp_in.kind          = ok ? KIND_IN : KIND_OUT;
            rsp_in.extent_offset = s3_hi0_ff ? s3_run_lo_ff : SAT41;
            rsp_in.extent_length = s3_len_ff;
            rsp_in.stream_id     = s3_stream_ff;
            if (ok) eff_in = effsum[41] ? SAT41 : effsum[40:0];
         end
         OP_FIN: begin
            produce             = 1'b1;
            rsp_in.kind         = KIND_END;
            rsp_in.stream_id    = s3_stream_ff;
            rsp_in.frame_status = s3_status_ff;
            rsp_in.frame_bytes  = eff_base;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         eff_ff     <= '0;
      end else if (adv) begin
         rsp_vld_ff <= s3_vld_ff && produce;
         if (s3_vld_ff) eff_ff <= eff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_vld_ff && produce) rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hdl/varint_extent_frame_decoder.sv =====
// Top level of the varint extent frame decoder: registers and block wiring.
//
//  channel  dir  handshake              payload
//  req_     in   req_valid/req_ready    req_data (req_type): one frame byte
//  rsp_     out  rsp_valid/rsp_ready    rsp_data (rsp_type): extent or frame end
//  csr_     in   csr_valid/csr_ready    csr_index, csr_data: register write
//
// One byte a cycle while the queue has room. A frame without the magic header, when
// the header skip is zero, stalls req_ready while the four held header bytes are
// replayed into the parser. Each byte passes the queue and three back-end stages.
// Synchronous reset clears the stream table valid bits at once; no clearing pass.
// A stalled rsp_ side holds the back end; the front keeps taking bytes until the
// four-entry queue fills.
`default_nettype none

module varint_extent_frame_decoder import vefd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [40:0] csr_data
);

   logic [7:0]  hskip_ff;
   logic [40:0] region_ff;

   logic    push, q_full, q_empty, pop, adv, op_vld;
   cmd_type push_cmd, q_cmd;
   op_type  op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hskip_ff  <= '0;
         region_ff <= REGION_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_SKIP: hskip_ff  <= csr_data[7:0];
            CSR_REGION_SIZE: region_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   vefd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .header_skip (hskip_ff),
      .push        (push),
      .push_cmd    (push_cmd),
      .q_full      (q_full)
   );

   vefd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   vefd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .q_empty (q_empty),
      .q_cmd   (q_cmd),
      .pop     (pop),
      .op_vld  (op_vld),
      .op      (op)
   );

   vefd_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .region_size (region_ff),
      .op_vld      (op_vld),
      .op          (op),
      .adv         (adv),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/vefd_checker.sv =====
// Port-level checks of the varint extent frame decoder, bound to the top level.
`default_nettype none

module vefd_checker import vefd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_type     rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_ext_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_END |->
         rsp_data.frame_status == ST_OK && rsp_data.frame_bytes == 41'd0)
      else $error("extent result carries frame fields");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_END |->
         rsp_data.extent_offset == 41'd0 && rsp_data.extent_length == 41'd0)
      else $error("frame end carries extent fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind varint_extent_frame_decoder vefd_checker u_vefd_checker (.*);

`default_nettype wire
